@@ rtl/smpq_pkg.sv @@
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and codes of the stable minimum priority queue
// Holds the action and status codes, the word carried by every cell and the
// command that the top level broadcasts down the row of cells.
// ----------------------------------------------------------------------------
package smpq_pkg;

   localparam int ValueWidth = 32;
   localparam int PrioWidth  = 8;
   localparam int CountWidth = 5;

   // Action codes of an input word. The fourth code behaves as a peek.
   localparam logic [1:0] ACTION_ENQUEUE = 2'd0;
   localparam logic [1:0] ACTION_DEQUEUE = 2'd1;
   localparam logic [1:0] ACTION_PEEK    = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // What every cell does in the current cycle.
   typedef enum logic [1:0] {
      OP_HOLD    = 2'd0,
      OP_ENQUEUE = 2'd1,
      OP_DEQUEUE = 2'd2
   } op_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic [PrioWidth-1:0]         prio;
   } entry_type;

   typedef struct packed {
      op_type                       op;
      logic signed [ValueWidth-1:0] value;
      logic [PrioWidth-1:0]         prio;
   } cmd_type;

endpackage

@@ rtl/smpq_cell.sv @@
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted cell row
// Holds one entry. On an enqueue it keeps its entry, takes the new one or
// takes its left neighbor's; on a dequeue it takes its right neighbor's.
// ----------------------------------------------------------------------------
module smpq_cell (
   input  logic                clock,
   input  smpq_pkg::cmd_type   cmd,
   input  logic                cell_valid,
   input  logic                prev_keep,
   input  smpq_pkg::entry_type prev_entry,
   input  smpq_pkg::entry_type next_entry,
   output logic                keep,
   output smpq_pkg::entry_type entry
);

   smpq_pkg::entry_type entry_ff;
   smpq_pkg::entry_type entry_in;

   // An occupied cell whose priority is lower or equal stays put, so equal
   // priorities keep their arrival order.
   assign keep  = cell_valid && (entry_ff.prio <= cmd.prio);
   assign entry = entry_ff;

   always_comb begin
      case (cmd.op)
         smpq_pkg::OP_ENQUEUE: begin
            if (keep) begin
               entry_in = entry_ff;
            end else if (prev_keep) begin
               entry_in.value = cmd.value;
               entry_in.prio  = cmd.prio;
            end else begin
               entry_in = prev_entry;
            end
         end
         smpq_pkg::OP_DEQUEUE: begin
            entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ rtl/stable_min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_min_priority_queue: bounded sorted priority queue
// A row of CAPACITY cells keeps entries in ascending priority order, with
// equal priorities in arrival order. Enqueue, dequeue and peek words.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (req_action, req_value, req_priority_req) is taken at a
//   rising edge with start high and busy low. Action enqueue inserts the
//   entry, dequeue removes the front entry, peek reads it; the unused fourth
//   code acts as a peek.
//   Every request word gives exactly one response word on rsp_status,
//   rsp_front_value and rsp_count, marked by rsp_valid for one cycle, in the
//   cycle right after the request was taken.
//   All cells compare their priority against the new entry in the same
//   cycle and shift by at most one place, so one word is taken every cycle;
//   busy stays low and the throughput is one word per clock.
//   An enqueue into a full queue is dropped with status full; a dequeue or
//   peek of an empty queue answers status empty with a zero value.
//   rsp_count gives the entries held after the word, in its low five bits.
//   A synchronous reset empties the queue and clears the response strobe;
//   cell contents are not cleared, since only occupied cells are ever read.
//   The receiver cannot hold a response off, so none is ever stalled.
// ----------------------------------------------------------------------------
module stable_min_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_action,
   input  logic signed [smpq_pkg::ValueWidth-1:0] req_value,
   input  logic [smpq_pkg::PrioWidth-1:0]         req_priority_req,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_status,
   output logic signed [smpq_pkg::ValueWidth-1:0] rsp_front_value,
   output logic [smpq_pkg::CountWidth-1:0]        rsp_count
);

   // The count must be able to hold CAPACITY itself.
   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   smpq_pkg::status_type                   rsp_status_ff;
   smpq_pkg::status_type                   rsp_status_in;
   logic signed [smpq_pkg::ValueWidth-1:0] rsp_front_value_ff;
   logic signed [smpq_pkg::ValueWidth-1:0] rsp_front_value_in;
   logic [smpq_pkg::CountWidth-1:0]        rsp_count_ff;
   logic [smpq_pkg::CountWidth-1:0]        rsp_count_in;

   smpq_pkg::cmd_type   cmd;
   smpq_pkg::entry_type cell_entry [CAPACITY];
   logic                cell_keep  [CAPACITY];

   logic accept;
   logic is_empty;
   logic is_full;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(CAPACITY));

   // Decode the request into the command every cell sees this cycle, and
   // form the response word and the new fill count.
   always_comb begin
      cmd.op             = smpq_pkg::OP_HOLD;
      cmd.value          = req_value;
      cmd.prio           = req_priority_req;
      count_in           = count_ff;
      rsp_status_in      = smpq_pkg::STATUS_OK;
      rsp_front_value_in = '0;
      if (accept) begin
         if (req_action == smpq_pkg::ACTION_ENQUEUE) begin
            if (is_full) begin
               rsp_status_in = smpq_pkg::STATUS_FULL;
            end else begin
               cmd.op   = smpq_pkg::OP_ENQUEUE;
               count_in = count_ff + CW'(1);
            end
         end else if (is_empty) begin
            rsp_status_in = smpq_pkg::STATUS_EMPTY;
         end else begin
            rsp_front_value_in = cell_entry[0].value;
            if (req_action == smpq_pkg::ACTION_DEQUEUE) begin
               cmd.op   = smpq_pkg::OP_DEQUEUE;
               count_in = count_ff - CW'(1);
            end
         end
      end
      rsp_valid_in = accept;
      rsp_count_in = smpq_pkg::CountWidth'(count_in);
   end

   // The row of cells. Cell zero is the front; the new entry enters where
   // the first cell stops keeping its own entry.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                cell_valid;
      logic                prev_keep;
      smpq_pkg::entry_type prev_entry;
      smpq_pkg::entry_type next_entry;

      assign cell_valid = (count_ff > CW'(i));

      if (i == 0) begin : g_first
         assign prev_keep  = 1'b1;
         assign prev_entry = '0;
      end else begin : g_inner
         assign prev_keep  = cell_keep[i-1];
         assign prev_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_body
         assign next_entry = cell_entry[i+1];
      end

      smpq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_valid (cell_valid),
         .prev_keep  (prev_keep),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .keep       (cell_keep[i]),
         .entry      (cell_entry[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff      <= rsp_status_in;
      rsp_front_value_ff <= rsp_front_value_in;
      rsp_count_ff       <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_front_value = rsp_front_value_ff;
   assign rsp_count       = rsp_count_ff;

   // The fill count never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   // Every accepted request gives a response in the next cycle.
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request without response");

   // A full status is only reported while every cell is occupied.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == smpq_pkg::STATUS_FULL) |->
         (count_ff == CW'(CAPACITY)))
      else $error("full status with free cells");

   // The two front cells stay in priority order.
   a_front_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
      else $error("front cells out of priority order");

endmodule
